[rtl/tks_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tks_pkg;

   localparam int KEEP_COUNT = 10;
   localparam int ID_W       = 31;
   localparam int SCORE_W    = 32;
   localparam int CNT_W      = $clog2(KEEP_COUNT + 1);
   localparam int IDX_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

   typedef logic [CNT_W-1:0] count_type;
   typedef logic [IDX_W-1:0] index_type;

   localparam count_type FULL_COUNT = count_type'(KEEP_COUNT);
   localparam index_type LAST_INDEX = index_type'(KEEP_COUNT - 1);

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
   } entry_type;

   // store update for one cycle: drop shifts entries above drop_pos down,
   // append then writes data at append_pos
   typedef struct packed {
      logic      append;
      logic      drop;
      index_type drop_pos;
      index_type append_pos;
      entry_type data;
   } store_cmd_type;

endpackage

`default_nettype wire

[rtl/tks_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tks_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [tks_pkg::ID_W-1:0]    item_id;
   logic [tks_pkg::SCORE_W-1:0] item_score;

   modport source (output valid, output mode, output item_id, output item_score,
                   input ready);
   modport sink   (input valid, input mode, input item_id, input item_score,
                   output ready);
endinterface

interface tks_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tks_pkg::ID_W-1:0]    out_id;
   logic [tks_pkg::SCORE_W-1:0] out_score;
   logic                        last;

   modport source (output valid, output out_id, output out_score, output last,
                   input ready);
   modport sink   (input valid, input out_id, input out_score, input last,
                   output ready);
endinterface

`default_nettype wire

[rtl/top_k_selector.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  word
// req_bus   in   mode, item_id[30:0], item_score[31:0]
// rsp_bus   out  out_id[30:0], out_score[31:0], last
//
// offer with fewer than KEEP_COUNT held: appended straight from idle, no scan
// offer when full: min scan on the one comparator, then evict
// flush of n entries: each emit is one min scan
// req ready only while the sequencer is idle; a flush emit waits for the
// rsp output register to be free, so rsp stalls stretch the flush
// reset clears the fill count, the sequencer and rsp valid, no clearing pass

module top_k_selector (
   input wire         clock,
   input wire         reset,
   tks_req_if.sink    req_bus,
   tks_rsp_if.source  rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_EVICT,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   tks_pkg::count_type      fill_ff, fill_in;
   tks_pkg::index_type      idx_ff, idx_in;
   tks_pkg::index_type      pos_ff, pos_in;
   tks_pkg::entry_type      min_ff, min_in;
   tks_pkg::entry_type      new_ff, new_in;
   logic                    flush_ff, flush_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tks_pkg::entry_type      rsp_entry_ff, rsp_entry_in;
   logic                    rsp_last_ff, rsp_last_in;

   tks_pkg::store_cmd_type  cmd;
   tks_pkg::index_type      rd_index;
   tks_pkg::entry_type      rd_entry;
   logic [tks_pkg::SCORE_W-1:0] cmp_a, cmp_b;
   logic                    cmp_lt;
   logic                    req_take;
   logic                    rsp_free;

   tks_store u_store (
      .clock    (clock),
      .cmd      (cmd),
      .rd_index (rd_index),
      .rd_entry (rd_entry)
   );

   // shared compare unit
   assign cmp_lt = cmp_a < cmp_b;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign req_take          = req_bus.valid && req_bus.ready;
   assign rsp_free          = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_id    = rsp_entry_ff.id;
   assign rsp_bus.out_score = rsp_entry_ff.score;
   assign rsp_bus.last      = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      min_in       = min_ff;
      new_in       = new_ff;
      flush_in     = flush_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;
      rd_index     = '0;
      cmp_a        = rd_entry.score;
      cmp_b        = min_ff.score;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               new_in   = '{id: req_bus.item_id, score: req_bus.item_score};
               flush_in = req_bus.mode;
               if (req_bus.mode) begin
                  if (fill_ff != '0) begin
                     state_in = ST_LOAD;
                  end
               end else if (fill_ff < tks_pkg::FULL_COUNT) begin
                  cmd.append     = 1'b1;
                  cmd.append_pos = fill_ff[tks_pkg::IDX_W-1:0];
                  cmd.data       = '{id: req_bus.item_id, score: req_bus.item_score};
                  fill_in        = fill_ff + tks_pkg::count_type'(1);
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            rd_index = '0;
            min_in   = rd_entry;
            pos_in   = '0;
            idx_in   = tks_pkg::index_type'(1);
            if (fill_ff == tks_pkg::count_type'(1)) begin
               state_in = flush_ff ? ST_EMIT : ST_EVICT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_index = idx_ff;
            cmp_a    = rd_entry.score;
            cmp_b    = min_ff.score;
            // strict compare keeps the earliest of equal minima
            if (cmp_lt) begin
               min_in = rd_entry;
               pos_in = idx_ff;
            end
            if (tks_pkg::count_type'(idx_ff) == fill_ff - tks_pkg::count_type'(1)) begin
               state_in = flush_ff ? ST_EMIT : ST_EVICT;
            end else begin
               idx_in = idx_ff + tks_pkg::index_type'(1);
            end
         end
         ST_EVICT: begin
            cmp_a = min_ff.score;
            cmp_b = new_ff.score;
            if (cmp_lt) begin
               cmd.drop       = 1'b1;
               cmd.drop_pos   = pos_ff;
               cmd.append     = 1'b1;
               cmd.append_pos = tks_pkg::LAST_INDEX;
               cmd.data       = new_ff;
            end
            state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = min_ff;
               rsp_last_in  = (fill_ff == tks_pkg::count_type'(1));
               cmd.drop     = 1'b1;
               cmd.drop_pos = pos_ff;
               fill_in      = fill_ff - tks_pkg::count_type'(1);
               state_in     = (fill_ff == tks_pkg::count_type'(1)) ? ST_IDLE : ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      min_ff       <= min_in;
      new_ff       <= new_in;
      flush_ff     <= flush_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= tks_pkg::FULL_COUNT)
      else $error("fill count beyond capacity");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (tks_pkg::count_type'(idx_ff) < fill_ff))
      else $error("scan index past held entries");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_take && !req_bus.mode && (fill_ff < tks_pkg::FULL_COUNT))
      |=> (fill_ff == $past(fill_ff) + tks_pkg::count_type'(1)))
      else $error("offer into free slot did not grow the store");

   a_emit_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && rsp_free)
      |=> (rsp_bus.valid && (rsp_bus.last == ($past(fill_ff) == tks_pkg::count_type'(1)))))
      else $error("emitted word or last flag wrong");
`endif

endmodule

`default_nettype wire

[rtl/tks_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module tks_store (
   input  wire                      clock,
   input  wire tks_pkg::store_cmd_type cmd,
   input  wire tks_pkg::index_type  rd_index,
   output tks_pkg::entry_type       rd_entry
);

   tks_pkg::entry_type entry_ff [tks_pkg::KEEP_COUNT];
   tks_pkg::entry_type entry_in [tks_pkg::KEEP_COUNT];

   always_comb begin
      for (int i = 0; i < tks_pkg::KEEP_COUNT; i++) begin
         entry_in[i] = entry_ff[i];
      end
      for (int i = 0; i < tks_pkg::KEEP_COUNT - 1; i++) begin
         if (cmd.drop && (tks_pkg::index_type'(i) >= cmd.drop_pos)) begin
            entry_in[i] = entry_ff[i + 1];
         end
      end
      for (int i = 0; i < tks_pkg::KEEP_COUNT; i++) begin
         if (cmd.append && (tks_pkg::index_type'(i) == cmd.append_pos)) begin
            entry_in[i] = cmd.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < tks_pkg::KEEP_COUNT; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   assign rd_entry = entry_ff[rd_index];

endmodule

`default_nettype wire
